[src/utf8vr_pkg.sv]
// shared types, constants and byte classification for the utf-8 repair core
package utf8vr_pkg;

    localparam logic [7:0] LEAD2_LO  = 8'hc2;
    localparam logic [7:0] LEAD2_HI  = 8'hdf;
    localparam logic [7:0] LEAD3_LO  = 8'he0;
    localparam logic [7:0] LEAD3_HI  = 8'hef;
    localparam logic [7:0] LEAD4_LO  = 8'hf0;
    localparam logic [7:0] LEAD4_HI  = 8'hf4;
    localparam logic [7:0] CONT_MASK = 8'hc0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] LIM_A0    = 8'ha0;
    localparam logic [7:0] LEAD_ED   = 8'hed;
    localparam logic [7:0] LIM_90    = 8'h90;
    localparam logic [7:0] REPL0     = 8'hef;
    localparam logic [7:0] REPL1     = 8'hbf;
    localparam logic [7:0] REPL2     = 8'hbd;

    localparam int RUN_MAX = 6;

    // lead classes
    localparam logic [2:0] LW_BAD   = 3'd0;
    localparam logic [2:0] LW_ASCII = 3'd1;
    localparam logic [2:0] LW_TWO   = 3'd2;
    localparam logic [2:0] LW_THREE = 3'd3;
    localparam logic [2:0] LW_FOUR  = 3'd4;

    // bytes released by one input beat
    typedef struct packed {
        logic [2:0]               count;
        logic [RUN_MAX-1:0][7:0]  bytes;
        logic [RUN_MAX-1:0]       repl;
        logic                     string_end;
        logic                     valid;
    } t_run;

    function automatic logic [2:0] lead_width(input logic [7:0] b);
        logic [2:0] w;
        if (b < CONT_TAG) begin
            w = LW_ASCII;
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            w = LW_TWO;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            w = LW_THREE;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            w = LW_FOUR;
        end else begin
            w = LW_BAD;
        end
        return w;
    endfunction

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        ok = 1'b1;
        if (lead == LEAD3_LO && b < LIM_A0) ok = 1'b0;
        if (lead == LEAD_ED && b >= LIM_A0) ok = 1'b0;
        if (lead == LEAD4_LO && b < LIM_90) ok = 1'b0;
        if (lead == LEAD4_HI && b >= LIM_90) ok = 1'b0;
        return ok;
    endfunction

endpackage

[src/utf8vr_decode.sv]
// sequence state and per-beat run builder
module utf8vr_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output utf8vr_pkg::t_run   o_run
);

    logic [2:0][7:0] r_pend;
    logic [2:0][7:0] n_pend;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    logic [2:0]      r_wid;
    logic [2:0]      n_wid;
    logic            r_err;
    logic            n_err;

    always_comb begin
        utf8vr_pkg::t_run run;
        logic [2:0] n;
        logic       lead_mode;
        logic       ok;
        logic       do_lead;
        logic [2:0] lw;

        run     = '0;
        n       = 3'd0;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_wid   = r_wid;
        n_err   = r_err;
        do_lead = 1'b0;
        ok      = 1'b0;

        lead_mode = (r_cnt == 2'd0) || (r_wid < 3'd2) || (r_wid > 3'd4)
                    || ({1'b0, r_cnt} >= r_wid);

        if (lead_mode) begin
            n_cnt   = 2'd0;
            n_wid   = 3'd0;
            do_lead = 1'b1;
        end else begin
            ok = (i_byte & utf8vr_pkg::CONT_MASK) == utf8vr_pkg::CONT_TAG;
            if (ok && r_cnt == 2'd1) ok = utf8vr_pkg::second_ok(r_pend[0], i_byte);
            if (ok) begin
                if ({1'b0, r_cnt} + 3'd1 == r_wid) begin
                    // sequence complete: release held bytes then this one
                    run.bytes[0] = r_pend[0];
                    n = 3'd1;
                    if (r_cnt >= 2'd2) begin
                        run.bytes[1] = r_pend[1];
                        n = 3'd2;
                    end
                    if (r_cnt == 2'd3) begin
                        run.bytes[2] = r_pend[2];
                        n = 3'd3;
                    end
                    run.bytes[n] = i_byte;
                    n = n + 3'd1;
                    n_cnt = 2'd0;
                    n_wid = 3'd0;
                end else begin
                    case (r_cnt)
                        2'd1:    n_pend[1] = i_byte;
                        2'd2:    n_pend[2] = i_byte;
                        default: n_pend[0] = i_byte;
                    endcase
                    n_cnt = r_cnt + 2'd1;
                end
            end else begin
                run.bytes[0] = utf8vr_pkg::REPL0;
                run.bytes[1] = utf8vr_pkg::REPL1;
                run.bytes[2] = utf8vr_pkg::REPL2;
                run.repl[2:0] = 3'b111;
                n       = 3'd3;
                n_err   = 1'b1;
                n_cnt   = 2'd0;
                n_wid   = 3'd0;
                do_lead = 1'b1;
            end
        end

        // breaking byte is retried as a new lead
        if (do_lead) begin
            lw = utf8vr_pkg::lead_width(i_byte);
            if (lw == utf8vr_pkg::LW_ASCII) begin
                run.bytes[n] = i_byte;
                n = n + 3'd1;
            end else if (lw == utf8vr_pkg::LW_BAD) begin
                run.bytes[n] = utf8vr_pkg::REPL0;
                run.repl[n]  = 1'b1;
                run.bytes[n + 3'd1] = utf8vr_pkg::REPL1;
                run.repl[n + 3'd1]  = 1'b1;
                run.bytes[n + 3'd2] = utf8vr_pkg::REPL2;
                run.repl[n + 3'd2]  = 1'b1;
                n = n + 3'd3;
                n_err = 1'b1;
            end else begin
                n_pend[0] = i_byte;
                n_cnt     = 2'd1;
                n_wid     = lw;
            end
        end else begin
            lw = utf8vr_pkg::LW_BAD;
        end

        if (i_last) begin
            // prefix cut off by the end of the string
            if (n_cnt != 2'd0) begin
                run.bytes[n] = utf8vr_pkg::REPL0;
                run.repl[n]  = 1'b1;
                run.bytes[n + 3'd1] = utf8vr_pkg::REPL1;
                run.repl[n + 3'd1]  = 1'b1;
                run.bytes[n + 3'd2] = utf8vr_pkg::REPL2;
                run.repl[n + 3'd2]  = 1'b1;
                n = n + 3'd3;
                n_err = 1'b1;
            end
            run.string_end = 1'b1;
            run.valid      = !n_err;
            n_cnt = 2'd0;
            n_wid = 3'd0;
            n_err = 1'b0;
        end

        run.count = n;
        o_run     = run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wid <= 3'd0;
            r_err <= 1'b0;
        end else if (i_take) begin
            r_cnt <= n_cnt;
            r_wid <= n_wid;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_pend <= n_pend;
        end
    end

endmodule

[src/utf8vr_emit.sv]
// run register that hands out one byte per output beat
module utf8vr_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  utf8vr_pkg::t_run   i_run,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_byte,
    output logic               o_run_last,
    output logic               o_string_end,
    output logic               o_replaced,
    output logic               o_string_valid
);

    utf8vr_pkg::t_run r_run;
    logic [2:0]       r_idx;
    logic             r_busy;
    logic             at_end;

    assign at_end         = (r_idx == r_run.count - 3'd1);
    assign o_valid        = r_busy;
    assign o_byte         = r_run.bytes[r_idx];
    assign o_replaced     = r_run.repl[r_idx];
    assign o_run_last     = at_end;
    assign o_string_end   = at_end && r_run.string_end;
    assign o_string_valid = at_end && r_run.string_end && r_run.valid;
    assign o_can_load     = !r_busy || (i_ready && at_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (i_load && i_run.count != 3'd0) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (r_busy && i_ready) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_run.count != 3'd0) begin
            r_run <= i_run;
        end
    end

endmodule

[src/utf8_validate_and_repair_core.sv]
// utf-8 validate and repair core: top level
//
//  channel  | valid    | ready    | payload
//  ---------+----------+----------+-----------------------------------------------
//  in       | i_valid  | o_ready  | i_in_byte, i_in_last
//  out      | o_valid  | i_ready  | o_out_byte, o_out_run_last, o_out_string_end,
//           |          |          | o_out_replaced, o_string_valid
//
// an input beat is decoded in the cycle it is accepted and its run (0 to 6 bytes)
// lands in the run register; the run register sends one byte per output beat.
// a run holds the run register until its last byte is sent, so with i_ready high plain
// ascii flows at one byte per cycle and a new input is taken on the last beat of a run.
// synchronous active-low reset clears the sequence state and empties the run register.
// a stall on the output holds the current byte and blocks input once the run is pending.
module utf8_validate_and_repair_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_run_last,
    output logic       o_out_string_end,
    output logic       o_out_replaced,
    output logic       o_string_valid
);

    utf8vr_pkg::t_run run;
    logic             take;
    logic             can_load;

    assign o_ready = can_load;
    assign take    = i_valid && can_load;

    utf8vr_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .o_run   (run)
    );

    utf8vr_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (take),
        .i_run          (run),
        .o_can_load     (can_load),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_byte         (o_out_byte),
        .o_run_last     (o_out_run_last),
        .o_string_end   (o_out_string_end),
        .o_replaced     (o_out_replaced),
        .o_string_valid (o_string_valid)
    );

endmodule

[dv/tb_utf8_validate_and_repair_core.sv]
// testbench for the utf-8 validate and repair core: directed table, random strings, scoreboard
`timescale 1ns / 100ps

module tb_utf8_validate_and_repair_core;

    localparam int N_DIR     = 26;
    localparam int N_RAND    = 144;
    localparam int N_QUIET   = 40;
    localparam int WATCHDOG  = 500;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
        logic       repl;
        logic       str_ok;
    } t_beat;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } t_stim;

    typedef enum logic [1:0] {ROW_MODEL, ROW_PASS, ROW_REPL} t_row_kind;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        t_row_kind  kind;
        logic       sv;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_out_run_last;
    logic       o_out_string_end;
    logic       o_out_replaced;
    logic       o_string_valid;

    // predictor state
    logic [7:0] pend_b [3];
    logic [1:0] pend_n   = 2'd0;
    logic [2:0] pend_w   = 3'd0;
    logic       bad_seen = 1'b0;

    t_beat out_beats[$];
    t_beat repaired_q[$];
    t_stim stim_q[$];

    int n_bad    = 0;
    int hold_n   = 0;
    int idle_cyc = 0;
    bit quiet    = 1'b0;

    // typed rows: ascii extremes, stray leads, string end after a stray byte
    t_dir_row dir_tab [N_DIR] = '{
        '{8'h00, 1'b0, ROW_PASS,  1'b0},
        '{8'h7f, 1'b0, ROW_PASS,  1'b0},
        '{8'h80, 1'b0, ROW_REPL,  1'b0},
        '{8'hc1, 1'b0, ROW_REPL,  1'b0},
        '{8'hf5, 1'b0, ROW_REPL,  1'b0},
        '{8'hff, 1'b1, ROW_REPL,  1'b0},
        // clean string with every width and the upper second-byte edges
        '{8'hdf, 1'b0, ROW_MODEL, 1'b0},
        '{8'hbf, 1'b0, ROW_MODEL, 1'b0},
        '{8'hed, 1'b0, ROW_MODEL, 1'b0},
        '{8'h9f, 1'b0, ROW_MODEL, 1'b0},
        '{8'hbf, 1'b0, ROW_MODEL, 1'b0},
        '{8'hf4, 1'b0, ROW_MODEL, 1'b0},
        '{8'h8f, 1'b0, ROW_MODEL, 1'b0},
        '{8'hbf, 1'b0, ROW_MODEL, 1'b0},
        '{8'hbf, 1'b1, ROW_MODEL, 1'b0},
        // second-byte limits broken, the byte is then a stray lead
        '{8'he0, 1'b0, ROW_MODEL, 1'b0},
        '{8'h9f, 1'b0, ROW_MODEL, 1'b0},
        '{8'hf0, 1'b0, ROW_MODEL, 1'b0},
        '{8'h8f, 1'b0, ROW_MODEL, 1'b0},
        '{8'hed, 1'b0, ROW_MODEL, 1'b0},
        '{8'ha0, 1'b0, ROW_MODEL, 1'b0},
        '{8'hf4, 1'b0, ROW_MODEL, 1'b0},
        '{8'h90, 1'b0, ROW_MODEL, 1'b0},
        // prefix broken by a new lead, then cut off by the string end
        '{8'hf1, 1'b0, ROW_MODEL, 1'b0},
        '{8'h80, 1'b0, ROW_MODEL, 1'b0},
        '{8'hc2, 1'b1, ROW_MODEL, 1'b0}
    };

    utf8_validate_and_repair_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_in_byte        (i_in_byte),
        .i_in_last        (i_in_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_out_run_last   (o_out_run_last),
        .o_out_string_end (o_out_string_end),
        .o_out_replaced   (o_out_replaced),
        .o_string_valid   (o_string_valid)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_beat mk_beat(input logic [7:0] data, input logic run_last,
                                      input logic str_end, input logic repl,
                                      input logic str_ok);
        t_beat r;
        r.data     = data;
        r.run_last = run_last;
        r.str_end  = str_end;
        r.repl     = repl;
        r.str_ok   = str_ok;
        return r;
    endfunction

    // 1 for ascii, 2..4 for a lead, 0 for a byte that cannot start a sequence
    function automatic int seq_len(input logic [7:0] b);
        if (b < utf8vr_pkg::CONT_TAG) return 1;
        if (b >= utf8vr_pkg::LEAD2_LO && b <= utf8vr_pkg::LEAD2_HI) return 2;
        if (b >= utf8vr_pkg::LEAD3_LO && b <= utf8vr_pkg::LEAD3_HI) return 3;
        if (b >= utf8vr_pkg::LEAD4_LO && b <= utf8vr_pkg::LEAD4_HI) return 4;
        return 0;
    endfunction

    function automatic logic second_in_range(input logic [7:0] lead, input logic [7:0] b);
        case (lead)
            utf8vr_pkg::LEAD3_LO: return b >= utf8vr_pkg::LIM_A0;
            utf8vr_pkg::LEAD_ED:  return b < utf8vr_pkg::LIM_A0;
            utf8vr_pkg::LEAD4_LO: return b >= utf8vr_pkg::LIM_90;
            utf8vr_pkg::LEAD4_HI: return b < utf8vr_pkg::LIM_90;
            default:              return 1'b1;
        endcase
    endfunction

    function automatic void push_repl();
        out_beats.push_back(mk_beat(utf8vr_pkg::REPL0, 1'b0, 1'b0, 1'b1, 1'b0));
        out_beats.push_back(mk_beat(utf8vr_pkg::REPL1, 1'b0, 1'b0, 1'b1, 1'b0));
        out_beats.push_back(mk_beat(utf8vr_pkg::REPL2, 1'b0, 1'b0, 1'b1, 1'b0));
        bad_seen = 1'b1;
    endfunction

    function automatic void open_seq(input logic [7:0] b);
        int w;
        w = seq_len(b);
        if (w == 1) begin
            out_beats.push_back(mk_beat(b, 1'b0, 1'b0, 1'b0, 1'b0));
        end else if (w == 0) begin
            push_repl();
        end else begin
            pend_b[0] = b;
            pend_n    = 2'd1;
            pend_w    = 3'(w);
        end
    endfunction

    // bytes the core releases for one input beat, left in out_beats
    function automatic void repair_step(input logic [7:0] b, input logic fin);
        logic  ok;
        int    i;
        t_beat tail;
        out_beats.delete();
        if (pend_n == 2'd0) begin
            open_seq(b);
        end else begin
            ok = (b & utf8vr_pkg::CONT_MASK) == utf8vr_pkg::CONT_TAG;
            if (ok && pend_n == 2'd1) ok = second_in_range(pend_b[0], b);
            if (!ok) begin
                push_repl();
                pend_n = 2'd0;
                pend_w = 3'd0;
                open_seq(b);
            end else if ({1'b0, pend_n} + 3'd1 == pend_w) begin
                for (i = 0; i < pend_n; i++) out_beats.push_back(mk_beat(pend_b[i], 1'b0,
                                                                         1'b0, 1'b0, 1'b0));
                out_beats.push_back(mk_beat(b, 1'b0, 1'b0, 1'b0, 1'b0));
                pend_n = 2'd0;
                pend_w = 3'd0;
            end else begin
                pend_b[pend_n] = b;
                pend_n = pend_n + 2'd1;
            end
        end
        if (fin) begin
            // a prefix cut off by the string end gets its own replacement
            if (pend_n != 2'd0) push_repl();
            if (out_beats.size() > 0) begin
                tail = out_beats.pop_back();
                tail.str_end = 1'b1;
                tail.str_ok  = !bad_seen;
                out_beats.push_back(tail);
            end
            pend_n   = 2'd0;
            pend_w   = 3'd0;
            bad_seen = 1'b0;
        end
        if (out_beats.size() > 0) begin
            tail = out_beats.pop_back();
            tail.run_last = 1'b1;
            out_beats.push_back(tail);
        end
    endfunction

    function automatic void put_stim(input logic [7:0] b);
        t_stim s;
        s.b   = b;
        s.fin = $urandom_range(0, 9) == 0;
        stim_q.push_back(s);
    endfunction

    function automatic logic [7:0] good_second(input logic [7:0] lead);
        case (lead)
            utf8vr_pkg::LEAD3_LO:
                return 8'($urandom_range(utf8vr_pkg::LIM_A0, 8'hbf));
            utf8vr_pkg::LEAD_ED:
                return 8'($urandom_range(utf8vr_pkg::CONT_TAG, utf8vr_pkg::LIM_A0 - 8'd1));
            utf8vr_pkg::LEAD4_LO:
                return 8'($urandom_range(utf8vr_pkg::LIM_90, 8'hbf));
            utf8vr_pkg::LEAD4_HI:
                return 8'($urandom_range(utf8vr_pkg::CONT_TAG, utf8vr_pkg::LIM_90 - 8'd1));
            default:
                return 8'($urandom_range(utf8vr_pkg::CONT_TAG, 8'hbf));
        endcase
    endfunction

    // byte that ends a prefix early: out-of-limit second byte or a non-continuation
    function automatic logic [7:0] break_byte(input logic [7:0] lead, input int good);
        if (good == 0 && $urandom_range(0, 1) == 1) begin
            case (lead)
                utf8vr_pkg::LEAD3_LO: return 8'($urandom_range(utf8vr_pkg::CONT_TAG,
                                                               utf8vr_pkg::LIM_A0 - 8'd1));
                utf8vr_pkg::LEAD_ED:  return 8'($urandom_range(utf8vr_pkg::LIM_A0, 8'hbf));
                utf8vr_pkg::LEAD4_LO: return 8'($urandom_range(utf8vr_pkg::CONT_TAG,
                                                               utf8vr_pkg::LIM_90 - 8'd1));
                utf8vr_pkg::LEAD4_HI: return 8'($urandom_range(utf8vr_pkg::LIM_90, 8'hbf));
                default:  ;
            endcase
        end
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 8'h7f));
        return 8'($urandom_range(utf8vr_pkg::CONT_MASK, 8'hff));
    endfunction

    // mostly well-formed sequences, some noise and some broken prefixes
    function automatic void gen_seq();
        int         pick, w, good, k;
        logic [7:0] lead;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            put_stim(8'($urandom_range(0, 8'h7f)));
        end else if (pick < 75) begin
            if (pick < 40) begin
                lead = 8'($urandom_range(utf8vr_pkg::LEAD2_LO, utf8vr_pkg::LEAD2_HI));
            end else if (pick < 55) begin
                lead = 8'($urandom_range(utf8vr_pkg::LEAD3_LO, utf8vr_pkg::LEAD3_HI));
            end else begin
                lead = 8'($urandom_range(utf8vr_pkg::LEAD4_LO, utf8vr_pkg::LEAD4_HI));
            end
            w = seq_len(lead);
            put_stim(lead);
            put_stim(good_second(lead));
            for (k = 2; k < w; k++) put_stim(8'($urandom_range(utf8vr_pkg::CONT_TAG, 8'hbf)));
        end else if (pick < 85) begin
            put_stim(8'($urandom_range(0, 8'hff)));
        end else begin
            lead = 8'($urandom_range(utf8vr_pkg::LEAD2_LO, utf8vr_pkg::LEAD4_HI));
            w    = seq_len(lead);
            good = $urandom_range(0, w - 2);
            put_stim(lead);
            for (k = 0; k < good; k++) begin
                if (k == 0) put_stim(good_second(lead));
                else put_stim(8'($urandom_range(utf8vr_pkg::CONT_TAG, 8'hbf)));
            end
            put_stim(break_byte(lead, good));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= fin;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_pause();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (repaired_q.size() != 0);
    endtask

    function automatic void cmp_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
        if (want !== got) begin
            n_bad++;
            $display("%0t: %s expected %02h actual %02h", $time, what, want, got);
        end
    endfunction

    // output side: scoreboard, random stalls, watchdog
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (repaired_q.size() == 0) begin
                n_bad++;
                $display("%0t: beat with nothing expected, expected none actual %02h",
                         $time, o_out_byte);
            end else begin
                want = repaired_q.pop_front();
                cmp_field("out_byte", want.data, o_out_byte);
                cmp_field("out_run_last", {7'd0, want.run_last}, {7'd0, o_out_run_last});
                cmp_field("out_string_end", {7'd0, want.str_end}, {7'd0, o_out_string_end});
                cmp_field("out_replaced", {7'd0, want.repl}, {7'd0, o_out_replaced});
                cmp_field("string_valid", {7'd0, want.str_ok}, {7'd0, o_string_valid});
            end
        end

        if (hold_n > 0) begin
            hold_n--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_n = $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end

        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cyc = 0;
        end else begin
            idle_cyc++;
            if (idle_cyc >= WATCHDOG) begin
                $display("utf8_validate_and_repair_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int    i;
        t_stim s;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIR; i++) begin
            send_byte(dir_tab[i].b, dir_tab[i].fin);
            repair_step(dir_tab[i].b, dir_tab[i].fin);
            case (dir_tab[i].kind)
                ROW_PASS: begin
                    repaired_q.push_back(mk_beat(dir_tab[i].b, 1'b1, dir_tab[i].fin, 1'b0,
                                                 dir_tab[i].sv));
                end
                ROW_REPL: begin
                    repaired_q.push_back(mk_beat(utf8vr_pkg::REPL0, 1'b0, 1'b0, 1'b1, 1'b0));
                    repaired_q.push_back(mk_beat(utf8vr_pkg::REPL1, 1'b0, 1'b0, 1'b1, 1'b0));
                    repaired_q.push_back(mk_beat(utf8vr_pkg::REPL2, 1'b1, dir_tab[i].fin, 1'b1,
                                                 dir_tab[i].sv));
                end
                default: begin
                    foreach (out_beats[k]) repaired_q.push_back(out_beats[k]);
                end
            endcase
        end
        drain_pause();

        while (stim_q.size() < N_RAND) gen_seq();
        // close the last string so the final beat carries the string end
        s = stim_q.pop_back();
        s.fin = 1'b1;
        stim_q.push_back(s);

        for (i = 0; i < stim_q.size(); i++) begin
            quiet = i >= stim_q.size() - N_QUIET;
            if (i == stim_q.size() / 2) drain_pause();
            send_byte(stim_q[i].b, stim_q[i].fin);
            repair_step(stim_q[i].b, stim_q[i].fin);
            foreach (out_beats[k]) repaired_q.push_back(out_beats[k]);
        end
        drain_pause();
        repeat (10) @(posedge i_clk);

        if (n_bad == 0) begin
            $display("utf8_validate_and_repair_core: match");
        end else begin
            $display("utf8_validate_and_repair_core: mismatch");
        end
        $finish;
    end

endmodule
